// ===== hdl/gwch_pkg.sv =====
`timescale 1ns / 1ps
package gwch_pkg;

  localparam int MAX_POINTS_DEF = 64;
  localparam int COORD_BITS_DEF = 16;
  localparam int ANGLE_BITS_DEF = 16;
  localparam int IDX_BITS = 6;

  typedef struct packed {
    logic signed [15:0] x_coord;
    logic signed [15:0] y_coord;
    logic               last_point;
  } in_word_t;

  typedef struct packed {
    logic [5:0] hull_index;
    logic       end_of_hull;
    logic       wrap_error;
  } out_word_t;

  // controller to datapath
  typedef struct packed {
    logic load;        // write input point at count
    logic clr_count;
    logic scan_init;   // start index scan, j = 0
    logic scan_step;   // compare y of read point
    logic set_cur;     // current <= start, heading <= 0
    logic rd_cur;      // address current point
    logic cap_cur;     // latch current point
    logic cordic_go;   // start angle of candidate j
    logic cand_init;   // clear best search
    logic cand_take;   // fold cordic result into best
    logic advance;     // current <= best, heading <= best theta
    logic j_inc;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic       count_full;
    logic       j_last;      // j == n-1
    logic       j_is_cur;
    logic       cordic_done;
    logic       found;
    logic       best_is_start;
    logic       cnt_ge_n;
  } dp_sts_t;

  // atan(2^-i), 32-bit binary angle
  function automatic logic [31:0] atan_lut(input logic [4:0] i);
    logic [31:0] r;
    case (i)
      5'd0:  r = 32'h20000000;  5'd1:  r = 32'h12E4051E;
      5'd2:  r = 32'h09FB385B;  5'd3:  r = 32'h051111D4;
      5'd4:  r = 32'h028B0D43;  5'd5:  r = 32'h0145D7E1;
      5'd6:  r = 32'h00A2F61E;  5'd7:  r = 32'h00517C55;
      5'd8:  r = 32'h0028BE53;  5'd9:  r = 32'h00145F2F;
      5'd10: r = 32'h000A2F98;  5'd11: r = 32'h000517CC;
      5'd12: r = 32'h00028BE6;  5'd13: r = 32'h000145F3;
      5'd14: r = 32'h0000A2FA;  5'd15: r = 32'h0000517D;
      5'd16: r = 32'h000028BE;  5'd17: r = 32'h0000145F;
      5'd18: r = 32'h00000A30;  5'd19: r = 32'h00000518;
      5'd20: r = 32'h0000028C;  5'd21: r = 32'h00000146;
      5'd22: r = 32'h000000A3;  5'd23: r = 32'h00000051;
      default: r = 32'h0;
    endcase
    return r;
  endfunction

endpackage

// ===== hdl/gwch_ram.sv =====
`timescale 1ns / 1ps
module gwch_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

// ===== hdl/gwch_cordic.sv =====
`timescale 1ns / 1ps
// Iterative CORDIC vectoring: one micro-rotation per cycle.
module gwch_cordic #(
  parameter int COORD_BITS = 16,
  parameter int ANGLE_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  go,
  input  logic [COORD_BITS:0]   dx,
  input  logic [COORD_BITS:0]   dy,
  output logic                  done,
  output logic [ANGLE_BITS-1:0] theta
);
  // dx,dy span COORD_BITS+1; after negation and gain growth keep 3 more
  localparam int W = COORD_BITS + 4;
  localparam int IW = $clog2(ANGLE_BITS + 1);

  logic signed [W-1:0] x, y;
  logic [31:0]         z;
  logic [IW-1:0]       it;
  logic                busy;

  logic signed [W-1:0] sdx, sdy, xs, ys;
  logic [31:0]         zr;

  assign sdx = W'(signed'(dx));
  assign sdy = W'(signed'(dy));
  assign xs  = x >>> it;
  assign ys  = y >>> it;
  assign zr  = z + (32'd1 << (31 - ANGLE_BITS));
  assign theta = zr[31 -: ANGLE_BITS];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (go) begin
        busy <= 1'b1;
        it   <= '0;
        if (sdx < 0) begin
          x <= -sdx; y <= -sdy; z <= 32'h80000000;
        end else begin
          x <= sdx;  y <= sdy;  z <= 32'h0;
        end
      end else if (busy) begin
        if (y == 0 || it == IW'(ANGLE_BITS)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          it <= it + 1'b1;
          if (y > 0) begin
            x <= x + ys; y <= y - xs; z <= z + gwch_pkg::atan_lut(5'(it));
          end else begin
            x <= x - ys; y <= y + xs; z <= z - gwch_pkg::atan_lut(5'(it));
          end
        end
      end
    end
  end
endmodule

// ===== hdl/gwch_datapath.sv =====
`timescale 1ns / 1ps
module gwch_datapath #(
  parameter int MAX_POINTS = 64,
  parameter int COORD_BITS = 16,
  parameter int ANGLE_BITS = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  gwch_pkg::in_word_t   in_word,
  input  gwch_pkg::dp_cmd_t    cmd,
  output gwch_pkg::dp_sts_t    sts,
  output logic [5:0]           start_idx,
  output logic [5:0]           best_idx
);
  localparam int AW = $clog2(MAX_POINTS);
  localparam int CW = $clog2(MAX_POINTS + 1);

  logic [CW-1:0] count, n, j, cnt;
  logic [AW-1:0] cur, start, best, raddr;
  logic [ANGLE_BITS-1:0] heading, best_turn, best_theta, theta, turn;
  logic found;
  logic [COORD_BITS-1:0] rx, ry, cx, cy, min_y;
  logic cdone;

  // point store
  gwch_ram #(.WIDTH(COORD_BITS), .DEPTH(MAX_POINTS)) u_xram (
    .clk, .we(cmd.load), .waddr(count[AW-1:0]),
    .wdata(COORD_BITS'(in_word.x_coord)), .raddr, .rdata(rx));
  gwch_ram #(.WIDTH(COORD_BITS), .DEPTH(MAX_POINTS)) u_yram (
    .clk, .we(cmd.load), .waddr(count[AW-1:0]),
    .wdata(COORD_BITS'(in_word.y_coord)), .raddr, .rdata(ry));

  assign raddr = cmd.rd_cur ? cur : j[AW-1:0];

  gwch_cordic #(.COORD_BITS(COORD_BITS), .ANGLE_BITS(ANGLE_BITS)) u_cordic (
    .clk, .rst, .go(cmd.cordic_go),
    .dx((COORD_BITS+1)'(signed'(rx)) - (COORD_BITS+1)'(signed'(cx))),
    .dy((COORD_BITS+1)'(signed'(ry)) - (COORD_BITS+1)'(signed'(cy))),
    .done(cdone), .theta);

  assign turn = theta - heading;

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0; n <= '0; j <= '0; cnt <= '0; cur <= '0; start <= '0;
      heading <= '0; found <= 1'b0; best <= '0;
    end else begin
      // set size includes the last point when it was stored
      if (cmd.clr_count) begin
        n <= count + CW'(cmd.load); count <= '0;
      end else if (cmd.load) begin
        count <= count + 1'b1;
      end
      if (cmd.scan_init) begin
        j <= '0; start <= '0;
      end
      if (cmd.scan_step) begin
        if (j == 0 || $signed(ry) < $signed(min_y)) begin
          start <= j[AW-1:0]; min_y <= ry;
        end
      end
      if (cmd.set_cur) begin
        cur <= start; heading <= '0; cnt <= CW'(1);
      end
      if (cmd.cap_cur) begin
        cx <= rx; cy <= ry;
      end
      if (cmd.cand_init) begin
        found <= 1'b0; j <= '0;
      end
      if (cmd.cand_take && (!found || turn < best_turn)) begin
        found <= 1'b1; best <= j[AW-1:0]; best_turn <= turn; best_theta <= theta;
      end
      if (cmd.j_inc) j <= j + 1'b1;
      if (cmd.advance) begin
        cur <= best; heading <= best_theta; cnt <= cnt + 1'b1;
      end
    end
  end

  always_comb begin
    sts.count_full    = (count == CW'(MAX_POINTS));
    sts.j_last        = (j == n - 1'b1);
    sts.j_is_cur      = (j[AW-1:0] == cur);
    sts.cordic_done   = cdone;
    sts.found         = found;
    sts.best_is_start = (best == start);
    sts.cnt_ge_n      = (cnt >= n);
  end

  assign start_idx = 6'(start);
  assign best_idx  = 6'(best);
endmodule

// ===== hdl/gwch_ctrl.sv =====
`timescale 1ns / 1ps
module gwch_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                in_last,
  output logic                out_valid,
  input  logic                out_ready,
  output gwch_pkg::out_word_t out_data,
  input  logic [5:0]          start_idx,
  input  logic [5:0]          best_idx,
  input  gwch_pkg::dp_sts_t   sts,
  output gwch_pkg::dp_cmd_t   cmd
);
  typedef enum logic [3:0] {
    S_LOAD, S_SCAN_RD, S_SCAN, S_EMIT0, S_CUR_RD, S_CUR, S_CAND,
    S_CAND_RD, S_CORDIC, S_DECIDE, S_EMIT, S_DRAIN
  } state_t;

  state_t              state;
  gwch_pkg::out_word_t hold;   // vertex word waiting for the next wrap step
  logic                accept;
  logic                close;
  logic                slot_free;
  logic                send;

  assign in_ready  = (state == S_LOAD);
  assign accept    = in_valid && in_ready;
  assign close     = !sts.found || sts.best_is_start || sts.cnt_ge_n;
  assign slot_free = !out_valid || out_ready;
  assign send      = slot_free && ((state == S_DECIDE && !close) || state == S_DRAIN);

  always_comb begin
    cmd = '0;
    cmd.load      = accept && !sts.count_full;
    cmd.clr_count = accept && in_last;
    unique case (state)
      S_LOAD:    cmd.scan_init = accept && in_last;
      S_SCAN_RD: ;
      S_SCAN:    begin cmd.scan_step = 1'b1; cmd.j_inc = !sts.j_last; end
      S_EMIT0:   ;
      S_CUR_RD:  cmd.rd_cur = 1'b1;
      S_CUR:     begin cmd.cap_cur = 1'b1; cmd.cand_init = 1'b1; end
      S_CAND:    ;
      S_CAND_RD: cmd.cordic_go = 1'b1;
      S_CORDIC:  begin
        cmd.cand_take = sts.cordic_done;
        cmd.j_inc     = sts.cordic_done && !sts.j_last;
      end
      S_DECIDE:  ;
      S_EMIT:    ;
      S_DRAIN:   ;
      default:   ;
    endcase
    if (state == S_EMIT0) cmd.set_cur = 1'b1;
    if (state == S_CAND && sts.j_is_cur && !sts.j_last) cmd.j_inc = 1'b1;
    if (state == S_DECIDE && !close && slot_free) cmd.advance = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_LOAD;
      out_valid <= 1'b0;
    end else begin
      // output register: load the held word, else retire an accepted one
      if (send) begin
        out_valid <= 1'b1;
        out_data  <= hold;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_LOAD: if (accept && in_last) state <= S_SCAN_RD;
        S_SCAN_RD: state <= S_SCAN;
        S_SCAN: if (sts.j_last) state <= S_EMIT0; else state <= S_SCAN_RD;
        S_EMIT0: begin
          // first vertex held until the wrap decides whether it is the last
          hold  <= '{hull_index: start_idx, end_of_hull: 1'b0, wrap_error: 1'b0};
          state <= S_CUR_RD;
        end
        S_CUR_RD: state <= S_CUR;
        S_CUR: state <= S_CAND;
        S_CAND: begin
          if (sts.j_is_cur) state <= sts.j_last ? S_DECIDE : S_CAND;
          else state <= S_CAND_RD;
        end
        S_CAND_RD: state <= S_CORDIC;
        S_CORDIC: if (sts.cordic_done) state <= sts.j_last ? S_DECIDE : S_CAND;
        S_DECIDE: begin
          if (close) begin
            // close the run on the held word
            hold.end_of_hull <= 1'b1;
            hold.wrap_error  <= sts.found && !sts.best_is_start;
            state <= S_DRAIN;
          end else if (slot_free) begin
            // held word goes out, the new vertex is held
            hold  <= '{hull_index: best_idx, end_of_hull: 1'b0, wrap_error: 1'b0};
            state <= S_EMIT;
          end
        end
        S_EMIT: state <= S_CUR_RD;
        S_DRAIN: if (slot_free) state <= S_LOAD;
        default: state <= S_LOAD;
      endcase
    end
  end
endmodule

// ===== hdl/gift_wrap_convex_hull_2d_unit.sv =====
`timescale 1ns / 1ps
// Gift-wrapping convex hull unit.
// Input channel: one point per word (x_coord, y_coord, last_point). Points
// are stored up to MAX_POINTS; extra points are dropped. A word with
// last_point set starts the wrap over the stored set.
// Output channel: hull vertex indices in wrap order; the last word carries
// end_of_hull, and wrap_error if the wrap failed to close.
// Loading accepts one point per cycle; the lowest-y scan then reads and
// compares each point in turn. During a run the input is not ready.
// Each wrap step evaluates every other point with one iterative CORDIC,
// one candidate at a time, and a run of h vertices takes h such steps.
// Each vertex word is emitted one step later, once the next step knows
// whether it closes the hull; a stalled receiver holds the wrap before
// the next word. Reset empties the point set and clears the output.
module gift_wrap_convex_hull_2d_unit #(
  parameter int MAX_POINTS = gwch_pkg::MAX_POINTS_DEF,
  parameter int COORD_BITS = gwch_pkg::COORD_BITS_DEF,
  parameter int ANGLE_BITS = gwch_pkg::ANGLE_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  gwch_pkg::in_word_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output gwch_pkg::out_word_t out_data
);
  gwch_pkg::dp_cmd_t cmd;
  gwch_pkg::dp_sts_t sts;
  logic [5:0] start_idx, best_idx;

  gwch_datapath #(.MAX_POINTS(MAX_POINTS), .COORD_BITS(COORD_BITS),
                  .ANGLE_BITS(ANGLE_BITS)) u_dp (
    .clk, .rst, .in_word(in_data), .cmd, .sts, .start_idx, .best_idx);

  gwch_ctrl u_ctrl (
    .clk, .rst, .in_valid, .in_ready, .in_last(in_data.last_point),
    .out_valid, .out_ready, .out_data, .start_idx, .best_idx, .sts, .cmd);
endmodule
